FILE: rtl/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants for the sonar obstacle-avoidance steering block.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int DIST_BITS = 10;
    localparam int THR_BITS  = 10;
    localparam int SPD_BITS  = 7;
    localparam int CMP_W     = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = THR_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_NEAR_THR = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MID_THR  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FAR_THR  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SLOW_SPD = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MED_SPD  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FAST_SPD = 3'd5;

    localparam logic [THR_BITS-1:0] NEAR_THR_RST = 10'd20;
    localparam logic [THR_BITS-1:0] MID_THR_RST  = 10'd40;
    localparam logic [THR_BITS-1:0] FAR_THR_RST  = 10'd80;
    localparam logic [SPD_BITS-1:0] SLOW_SPD_RST = 7'd30;
    localparam logic [SPD_BITS-1:0] MED_SPD_RST  = 7'd60;
    localparam logic [SPD_BITS-1:0] FAST_SPD_RST = 7'd100;

    typedef enum logic [1:0] {
        HD_FWD,
        HD_BWD,
        HD_TL,
        HD_TR
    } heading_t;

    typedef enum logic [2:0] {
        MC_STOP,
        MC_FWD,
        MC_BWD,
        MC_LEFT,
        MC_RIGHT
    } motor_cmd_t;

    typedef struct packed {
        motor_cmd_t cmd;
        heading_t   hd;
    } move_t;

    typedef struct packed {
        logic [THR_BITS-1:0] near_threshold;
        logic [THR_BITS-1:0] mid_threshold;
        logic [THR_BITS-1:0] far_threshold;
        logic [SPD_BITS-1:0] slow_speed;
        logic [SPD_BITS-1:0] medium_speed;
        logic [SPD_BITS-1:0] fast_speed;
    } cfg_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] dist_middle;
        logic [DIST_BITS-1:0] dist_right;
        logic [DIST_BITS-1:0] dist_left;
        logic [DIST_BITS-1:0] dist_back;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]          motor_command;
        logic [1:0]          heading;
        logic [SPD_BITS-1:0] drive_speed;
    } out_beat_t;

endpackage

FILE: rtl/soa_cfg_regs.sv
// ----------------------------------------------------------------------------
// soa_cfg_regs
// Threshold and speed registers behind the plain write port.
// ----------------------------------------------------------------------------
module soa_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [soa_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [soa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output soa_pkg::cfg_t                      cfg
);
    import soa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_NEAR_THR: cfg_next.near_threshold = cfg_wdata[THR_BITS-1:0];
                CFG_MID_THR:  cfg_next.mid_threshold  = cfg_wdata[THR_BITS-1:0];
                CFG_FAR_THR:  cfg_next.far_threshold  = cfg_wdata[THR_BITS-1:0];
                CFG_SLOW_SPD: cfg_next.slow_speed     = cfg_wdata[SPD_BITS-1:0];
                CFG_MED_SPD:  cfg_next.medium_speed   = cfg_wdata[SPD_BITS-1:0];
                CFG_FAST_SPD: cfg_next.fast_speed     = cfg_wdata[SPD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_threshold <= NEAR_THR_RST;
            cfg_reg.mid_threshold  <= MID_THR_RST;
            cfg_reg.far_threshold  <= FAR_THR_RST;
            cfg_reg.slow_speed     <= SLOW_SPD_RST;
            cfg_reg.medium_speed   <= MED_SPD_RST;
            cfg_reg.fast_speed     <= FAST_SPD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/soa_speed_sel.sv
// ----------------------------------------------------------------------------
// soa_speed_sel
// Drive speed from the nearest of the three front distances.
// ----------------------------------------------------------------------------
module soa_speed_sel (
    input  soa_pkg::in_beat_t               beat,
    input  soa_pkg::cfg_t                   cfg,
    output logic [soa_pkg::SPD_BITS-1:0]    speed
);
    import soa_pkg::*;

    logic [DIST_BITS-1:0] min_mr;
    logic [DIST_BITS-1:0] min_front;
    logic [CMP_W-1:0]     min_x;

    always_comb begin
        min_mr    = (beat.dist_right < beat.dist_middle) ? beat.dist_right : beat.dist_middle;
        min_front = (beat.dist_left < min_mr) ? beat.dist_left : min_mr;
        min_x     = CMP_W'(min_front);
        if (min_x < CMP_W'(cfg.near_threshold)) begin
            speed = cfg.slow_speed;
        end else if (min_x >= CMP_W'(cfg.far_threshold)) begin
            speed = cfg.fast_speed;
        end else if (min_x >= CMP_W'(cfg.mid_threshold)) begin
            speed = cfg.medium_speed;
        end else begin
            speed = cfg.slow_speed;
        end
    end

endmodule

FILE: rtl/soa_steer_rules.sv
// ----------------------------------------------------------------------------
// soa_steer_rules
// Heading rule blocks in fixed order; each block sees the heading left by
// the blocks before it.
// ----------------------------------------------------------------------------
module soa_steer_rules (
    input  soa_pkg::in_beat_t  beat,
    input  soa_pkg::cfg_t      cfg,
    input  soa_pkg::move_t     move_cur,
    output soa_pkg::move_t     move_next
);
    import soa_pkg::*;

    typedef struct packed {
        logic mh;
        logic ml;
        logic lh;
        logic ll;
        logic rh;
        logic rl;
        logic bclear;
        logic bblk;
        logic l_gt_r;
    } flags_t;

    flags_t f;
    move_t  mv_fwd;
    move_t  mv_bwd;
    move_t  mv_tl;

    function automatic move_t side(input flags_t fl);
        move_t r;
        r.cmd = fl.l_gt_r ? MC_LEFT : MC_RIGHT;
        r.hd  = fl.l_gt_r ? HD_TL : HD_TR;
        return r;
    endfunction

    function automatic move_t mk(input motor_cmd_t c, input heading_t h);
        move_t r;
        r.cmd = c;
        r.hd  = h;
        return r;
    endfunction

    function automatic move_t blk_fwd(input move_t mi, input flags_t fl);
        move_t r;
        r = mi;
        if (fl.mh && fl.lh && fl.rh) r = mk(MC_FWD, HD_FWD);
        if (fl.mh && fl.lh && fl.rl) r = mk(MC_LEFT, HD_TL);
        if (fl.mh && fl.ll && fl.rh) r = mk(MC_RIGHT, HD_TR);
        if (fl.ml && fl.ll && fl.rl) r = mk(MC_BWD, HD_BWD);
        if (fl.ml && fl.lh && fl.rh) r = side(fl);
        if (fl.mh && fl.ll && fl.rl) r = mk(MC_BWD, HD_BWD);
        return r;
    endfunction

    function automatic move_t blk_bwd(input move_t mi, input flags_t fl);
        move_t r;
        r = mi;
        if (fl.mh && fl.lh && fl.rh && fl.bclear) r = side(fl);
        if (fl.mh && fl.lh && fl.rl && fl.bclear) r = mk(MC_RIGHT, HD_BWD);
        if (fl.mh && fl.ll && fl.rh && fl.bclear) r = mk(MC_LEFT, HD_BWD);
        if (fl.ml && fl.ll && fl.rl && fl.bclear) r = mk(MC_BWD, HD_BWD);
        if (fl.ml && fl.lh && fl.rh && fl.bclear) r = side(fl);
        if (fl.mh && fl.ll && fl.rl && fl.bclear) r = mk(MC_BWD, HD_BWD);
        if (fl.bblk) r = side(fl);
        if (fl.ml && fl.ll && fl.rl && fl.bblk) r = mk(MC_STOP, HD_BWD);
        return r;
    endfunction

    function automatic move_t blk_tl(input move_t mi, input flags_t fl);
        move_t r;
        r = mi;
        if (fl.mh && fl.lh && fl.rh) r = mk(MC_FWD, HD_FWD);
        if (fl.mh && fl.lh && fl.rl) r = mk(MC_LEFT, HD_TL);
        if (fl.ml && fl.ll && fl.rl) r = mk(MC_BWD, HD_BWD);
        return r;
    endfunction

    function automatic move_t blk_tr(input move_t mi, input flags_t fl);
        move_t r;
        r = mi;
        if (fl.mh && fl.lh && fl.rh) r = mk(MC_FWD, HD_FWD);
        if (fl.mh && fl.ll && fl.rh) r = mk(MC_RIGHT, HD_TR);
        if (fl.ml && fl.ll && fl.rl) r = mk(MC_BWD, HD_BWD);
        return r;
    endfunction

    always_comb begin
        f.mh     = CMP_W'(beat.dist_middle) > CMP_W'(cfg.near_threshold);
        f.ml     = CMP_W'(beat.dist_middle) < CMP_W'(cfg.near_threshold);
        f.lh     = CMP_W'(beat.dist_left)   > CMP_W'(cfg.near_threshold);
        f.ll     = CMP_W'(beat.dist_left)   < CMP_W'(cfg.near_threshold);
        f.rh     = CMP_W'(beat.dist_right)  > CMP_W'(cfg.near_threshold);
        f.rl     = CMP_W'(beat.dist_right)  < CMP_W'(cfg.near_threshold);
        f.bclear = CMP_W'(beat.dist_back)   > CMP_W'(cfg.far_threshold);
        f.bblk   = CMP_W'(beat.dist_back)   < CMP_W'(cfg.near_threshold);
        f.l_gt_r = beat.dist_left > beat.dist_right;
    end

    always_comb begin
        mv_fwd    = (move_cur.hd == HD_FWD) ? blk_fwd(move_cur, f) : move_cur;
        mv_bwd    = (mv_fwd.hd == HD_BWD) ? blk_bwd(mv_fwd, f) : mv_fwd;
        mv_tl     = (mv_bwd.hd == HD_TL) ? blk_tl(mv_bwd, f) : mv_bwd;
        move_next = (mv_tl.hd == HD_TR) ? blk_tr(mv_tl, f) : mv_tl;
    end

endmodule

FILE: rtl/sonar_obstacle_avoid_fsm.sv
// ----------------------------------------------------------------------------
// sonar_obstacle_avoid_fsm
// Sonar obstacle-avoidance steering: heading state machine and speed choice.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one beat of four sonar distances (middle,
//   right, left, back). m_valid/m_ready/m_data return one beat per input:
//   motor command, new heading and drive speed.
//   cfg_we/cfg_addr/cfg_wdata write the three distance thresholds and the
//   three speed duties; write only while no beat is in flight.
//   Path: a beat accepted is loaded into the input register, evaluated
//   there by the rule and speed logic, and its result is loaded into the
//   result register, which drives m_data.
//   Throughput: one beat per cycle while m_ready is high; the heading state
//   loop runs through the rule logic and the heading state register.
//   Stall: with a result waiting and m_ready low the result register holds;
//   the input register takes one more beat; s_ready drops only when both hold.
//   Reset: heading forward, last command stop, both registers empty and
//   the configuration back to its default thresholds and duties.
// ----------------------------------------------------------------------------
module sonar_obstacle_avoid_fsm (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  soa_pkg::in_beat_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output soa_pkg::out_beat_t                 m_data,
    input  logic                               cfg_we,
    input  logic [soa_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [soa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import soa_pkg::*;

    cfg_t      cfg;
    in_beat_t  in_reg;
    logic      in_valid_reg;
    out_beat_t out_reg;
    out_beat_t out_next;
    logic      out_valid_reg;
    move_t     move_reg;
    move_t     move_next;
    logic [SPD_BITS-1:0] speed;
    logic      out_free;
    logic      advance;

    soa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    soa_speed_sel u_speed (
        .beat  (in_reg),
        .cfg   (cfg),
        .speed (speed)
    );

    soa_steer_rules u_steer (
        .beat      (in_reg),
        .cfg       (cfg),
        .move_cur  (move_reg),
        .move_next (move_next)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        out_next.motor_command = move_next.cmd;
        out_next.heading       = move_next.hd;
        out_next.drive_speed   = speed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            move_reg      <= '{cmd: MC_STOP, hd: HD_FWD};
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                move_reg <= move_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance) |=> (m_data.motor_command == move_reg.cmd
                                  && m_data.heading == move_reg.hd))
        else $error("result beat differs from stored heading state");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !advance) |=> $stable(move_reg))
        else $error("heading state moved without a beat");

    a_ready_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled while a stage was free");

    a_cmd_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.motor_command <= MC_RIGHT))
        else $error("motor command out of range");

endmodule
